FILE: src/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by isort_cell and insertion_sorter.
package isort_pkg;

	localparam int DATA_W        = 32;
	localparam int CNT_W         = 7;
	localparam int MAX_COUNT_DEF = 64;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;    // insert the broadcast key
		logic             shift;  // move every entry one place toward cell 0
		logic [CNT_W-1:0] count;  // entries held before this cycle
	} cell_ctl_t;

endpackage

FILE: src/isort_cell.sv
// One cell of the sorting chain: holds a single ordered entry.
// Depends on isort_pkg for the command struct and widths.
module isort_cell #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  isort_pkg::cell_ctl_t                ctl,
	input  logic signed [isort_pkg::DATA_W-1:0] key,
	input  logic signed [isort_pkg::DATA_W-1:0] left_val,
	input  logic                                left_gt,
	input  logic signed [isort_pkg::DATA_W-1:0] right_val,
	output logic signed [isort_pkg::DATA_W-1:0] val,
	output logic                                gt
);

	logic signed [isort_pkg::DATA_W-1:0] val_q;
	logic                                held;
	logic                                first_free;

	assign held       = isort_pkg::CNT_W'(IDX) < ctl.count;
	assign first_free = isort_pkg::CNT_W'(IDX) == ctl.count;
	assign gt         = held && (val_q > key);
	assign val        = val_q;

	// A larger entry steps up; the free slot after the last entry takes
	// the key or the larger neighbor from below. During a drain each cell takes the entry above it.
	always_ff @(posedge clk) begin
		if (ctl.ins && (gt || first_free)) begin
			val_q <= left_gt ? left_val : key;
		end else if (ctl.shift) begin
			val_q <= right_val;
		end
	end

endmodule

FILE: src/insertion_sorter.sv
// Top level of the insertion sorter: control and the chain of cells.
// Depends on isort_pkg and isort_cell.
//
// Usage: present value and is_last with start high; the item is taken at
// a rising edge where start is high and busy is low. Each value enters the
// chain in that cycle: every cell compares against the broadcast key at
// once and larger entries move up one place, so items of a run can be
// taken one per cycle. Equal values keep their arrival order.
// The item with is_last set closes the run. From the next cycle busy is
// high while the held entries leave one per cycle, smallest first. Each
// is on the ports in the cycle after its drain cycle, with strobe high for
// exactly one cycle; end_of_run marks the largest. Busy drops in the
// cycle that carries the final result, and the next run may start then.
// Values beyond MAX_COUNT are discarded and overflow is set on every
// result of that run. The receiver cannot stall the output.
// Reset (arst_n low) empties the chain and clears strobe and busy.
module insertion_sorter #(
	parameter int MAX_COUNT = isort_pkg::MAX_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                                is_last,
	output logic                                strobe,
	output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
	output logic                                end_of_run,
	output logic                                overflow
);

	logic [isort_pkg::CNT_W-1:0] count_q;
	logic                        drop_q;
	logic                        drain_q;
	logic                        strobe_q;
	logic                        end_q;
	logic                        ovf_q;
	logic signed [isort_pkg::DATA_W-1:0] out_q;

	logic                 accept;
	logic                 has_room;
	isort_pkg::cell_ctl_t ctl;

	logic signed [isort_pkg::DATA_W-1:0] cell_val [MAX_COUNT];
	logic                                cell_gt  [MAX_COUNT];

	assign accept    = start && !drain_q;
	assign has_room  = count_q < isort_pkg::CNT_W'(MAX_COUNT);
	assign ctl.ins   = accept && has_room;
	assign ctl.shift = drain_q;
	assign ctl.count = count_q;

	genvar i;
	generate
		for (i = 0; i < MAX_COUNT; i++) begin : g_cell
			logic signed [isort_pkg::DATA_W-1:0] lv;
			logic                                lg;
			logic signed [isort_pkg::DATA_W-1:0] rv;
			if (i == 0) begin : g_first
				assign lv = '0;
				assign lg = 1'b0;
			end else begin : g_mid
				assign lv = cell_val[i-1];
				assign lg = cell_gt[i-1];
			end
			if (i == MAX_COUNT - 1) begin : g_top
				assign rv = '0;
			end else begin : g_below
				assign rv = cell_val[i+1];
			end
			isort_cell #(.IDX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.key       (value),
				.left_val  (lv),
				.left_gt   (lg),
				.right_val (rv),
				.val       (cell_val[i]),
				.gt        (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			drop_q   <= 1'b0;
			drain_q  <= 1'b0;
			strobe_q <= 1'b0;
			end_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (drain_q) begin
			// emit cell 0 while the chain moves down
			strobe_q <= 1'b1;
			end_q    <= count_q == isort_pkg::CNT_W'(1);
			ovf_q    <= drop_q;
			count_q  <= count_q - isort_pkg::CNT_W'(1);
			if (count_q == isort_pkg::CNT_W'(1)) begin
				drain_q <= 1'b0;
				drop_q  <= 1'b0;
			end
		end else begin
			strobe_q <= 1'b0;
			end_q    <= 1'b0;
			if (accept) begin
				if (has_room) begin
					count_q <= count_q + isort_pkg::CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
				if (is_last) begin
					drain_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q) begin
			out_q <= cell_val[0];
		end
	end

	assign busy         = drain_q;
	assign strobe       = strobe_q;
	assign sorted_value = out_q;
	assign end_of_run   = end_q;
	assign overflow     = ovf_q;

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> count_q != '0)
		else $error("draining with an empty chain");

	a_strobe_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(drain_q))
		else $error("result strobe without a drain cycle");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drain_q) |-> (strobe_q && end_q))
		else $error("drain ended without the final result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= isort_pkg::CNT_W'(MAX_COUNT))
		else $error("held count above capacity");

	a_end_once: assert property (@(posedge clk) disable iff (!arst_n)
		end_q |-> !drain_q)
		else $error("final result while entries remain");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for insertion_sorter: directed and random runs.
// Depends on isort_pkg and the insertion_sorter RTL; a scoreboard class predicts each run.
module tb;

	localparam int CAP      = isort_pkg::MAX_COUNT_DEF;
	localparam int N_ITEMS  = 400;
	localparam int MAX_GAP  = 6;
	localparam int DRAIN    = 2 * CAP + 20;

	typedef logic signed [isort_pkg::DATA_W-1:0] key_t;

	typedef struct {
		key_t value;
		logic last;
		logic ovf;
	} sorted_entry_t;

	// Keeps its own ordered copy of the run and queues the sorted output due.
	class sorted_run_board_t;
		key_t          held[CAP];
		int            held_n;
		bit            dropped;
		int            cap;
		sorted_entry_t sorted_due[$];
		int            errors;

		function new(int capacity);
			cap     = capacity;
			held_n  = 0;
			dropped = 0;
			errors  = 0;
		endfunction

		function void note_item(key_t key, logic is_last);
			int pos;
			sorted_entry_t e;
			if (held_n < cap) begin
				pos = held_n;
				// shift strictly larger entries up; equal keys stay below
				while (pos > 0 && held[pos-1] > key) begin
					held[pos] = held[pos-1];
					pos--;
				end
				held[pos] = key;
				held_n++;
			end else begin
				dropped = 1;
			end
			if (is_last) begin
				for (int k = 0; k < held_n; k++) begin
					e.value = held[k];
					e.last  = (k == held_n - 1);
					e.ovf   = dropped;
					sorted_due.push_back(e);
				end
				held_n  = 0;
				dropped = 0;
			end
		endfunction

		function void check_result(key_t value, logic last, logic ovf);
			sorted_entry_t e;
			if (sorted_due.size() == 0) begin
				$error("unexpected result: sorted_value %0d", value);
				errors++;
				return;
			end
			e = sorted_due.pop_front();
			if (value !== e.value) begin
				$error("sorted_value: expected %0d, got %0d", e.value, value);
				errors++;
			end
			if (last !== e.last) begin
				$error("end_of_run: expected %0b, got %0b", e.last, last);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0b, got %0b", e.ovf, ovf);
				errors++;
			end
		endfunction

		function void check_drained();
			if (sorted_due.size() != 0) begin
				$error("%0d results never arrived", sorted_due.size());
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	key_t value;
	logic is_last;
	logic strobe;
	key_t sorted_value;
	logic end_of_run;
	logic overflow;

	sorted_run_board_t board = new(CAP);
	int                items_sent;

	insertion_sorter #(.MAX_COUNT(CAP)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.is_last      (is_last),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.end_of_run   (end_of_run),
		.overflow     (overflow)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_result(sorted_value, end_of_run, overflow);
	end

	// Present one item after an idle gap of the given length and hold it until taken.
	task automatic drive_item(input key_t v, input logic last, input int gap);
		bit taken;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		value   <= v;
		is_last <= last;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1;
				board.note_item(v, last);
				items_sent++;
			end
		end
	endtask

	task automatic send_run(input key_t vals[$], input bit burst);
		for (int i = 0; i < vals.size(); i++)
			drive_item(vals[i], i == vals.size() - 1, burst ? 0 : $urandom_range(0, MAX_GAP));
	endtask

	function automatic key_t draw_key(int mode);
		key_t k;
		case (mode)
			1: k = $signed($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 4))
					0: k = {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};
					1: k = {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};
					2: k = '0;
					3: k = '1;
					default: k = $urandom;
				endcase
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	initial begin
		key_t vals[$];
		int   run_idx;
		int   len;
		int   mode;
		bit   burst;
		int   wait_n;

		arst_n     = 1'b0;
		start      = 1'b0;
		value      = '0;
		is_last    = 1'b0;
		items_sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// single extremes, mixed extremes with duplicates, equal keys, reversed order, mixed signs
		vals = '{32'sh7fffffff};
		send_run(vals, 1);
		vals = '{32'sh80000000};
		send_run(vals, 0);
		vals = '{0, -1, 32'sh7fffffff, 32'sh80000000, 1, 32'sh80000000, 32'sh7fffffff, 0};
		send_run(vals, 1);
		vals = '{5, 5, 5};
		send_run(vals, 0);
		vals = '{3, 2, 1, 0, -1, -2};
		send_run(vals, 1);
		vals = '{-7, 7, 8};
		send_run(vals, 0);

		// mostly short runs; every tenth run nearly fills the store, often past its end
		run_idx = 0;
		while (items_sent < N_ITEMS) begin
			if (run_idx % 10 == 9)
				len = $urandom_range(CAP - 4, CAP + 8);
			else
				len = $urandom_range(1, 8);
			mode  = $urandom_range(0, 3);
			burst = ($urandom_range(0, 2) == 0);
			vals.delete();
			for (int i = 0; i < len; i++)
				vals.push_back(draw_key(mode));
			send_run(vals, burst);
			run_idx++;
		end
		@(negedge clk);
		start <= 1'b0;

		wait_n = 0;
		while (board.sorted_due.size() != 0 && wait_n < 100 * DRAIN) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (DRAIN) @(posedge clk);
		board.check_drained();
		if (board.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule
